@@ hdl/fpss_pkg.sv @@
// Package for the flight phase safety sequencer: phase, operation and stop-cause codes,
// register map indexes and register reset values.
// No dependencies.
`timescale 1ns / 1ps

package fpss_pkg;

   typedef enum logic [2:0] {
      PH_BOOT      = 3'd0,
      PH_READY     = 3'd1,
      PH_ARMING    = 3'd2,
      PH_HOVERING  = 3'd3,
      PH_DISARMING = 3'd4,
      PH_HALTED    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_CAL_DONE  = 2'd1,
      OP_ARM_DONE  = 2'd2,
      OP_EXT_STOP  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CAUSE_NONE = 2'd0,
      CAUSE_IMU  = 2'd1,
      CAUSE_TILT = 2'd2,
      CAUSE_EXT  = 2'd3
   } cause_type;

   typedef enum logic [1:0] {
      REG_ARM_DELAY  = 2'd0,
      REG_HOVER_DUR  = 2'd1,
      REG_TILT_LIMIT = 2'd2,
      REG_SPIN_DOWN  = 2'd3
   } reg_index_type;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int TIME_W     = 32;
   localparam int ANGLE_W    = 16;
   localparam int TILT_W     = 15;
   localparam int SPIN_W     = 16;

   localparam logic [TIME_W-1:0] ARM_DELAY_RST  = '0;
   localparam logic [TIME_W-1:0] HOVER_DUR_RST  = '0;
   localparam logic [TILT_W-1:0] TILT_LIMIT_RST = 15'd7040;  // 55 degrees
   localparam logic [SPIN_W-1:0] SPIN_DOWN_RST  = 16'd1000;

endpackage

@@ hdl/flight_phase_safety_sequencer.sv @@
// Flight phase safety sequencer top level: input register, phase update logic,
// result register and APB-style register file. Depends on fpss_pkg.
// A transaction passes through the input register, then the result register,
// before its result can be accepted.
// Throughput: one transaction per cycle unless rsp_stall holds; the phase update
// is one compare and subtract stage between the input and result registers.
// Reset (synchronous, active high) returns phase to boot, clears the emergency
// latch, stop cause and phase start time, and loads the register reset values.
`timescale 1ns / 1ps

module flight_phase_safety_sequencer
   import fpss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_op,
   input  logic [TIME_W-1:0]     req_now_ms,
   input  logic                  req_imu_healthy,
   input  logic signed [ANGLE_W-1:0] req_roll_angle,
   input  logic signed [ANGLE_W-1:0] req_pitch_angle,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_phase,
   output logic                  rsp_cut_power,
   output logic                  rsp_motor_stop_pulse,
   output logic                  rsp_emergency,
   output logic [1:0]            rsp_stop_cause,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // configuration registers
   logic [TIME_W-1:0] arm_delay_ff;
   logic [TIME_W-1:0] hover_dur_ff;
   logic [TILT_W-1:0] tilt_limit_ff;
   logic [SPIN_W-1:0] spin_down_ff;
   logic              csr_wr;
   reg_index_type     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_delay_ff  <= ARM_DELAY_RST;
         hover_dur_ff  <= HOVER_DUR_RST;
         tilt_limit_ff <= TILT_LIMIT_RST;
         spin_down_ff  <= SPIN_DOWN_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ARM_DELAY:  arm_delay_ff  <= csr_pwdata[TIME_W-1:0];
            REG_HOVER_DUR:  hover_dur_ff  <= csr_pwdata[TIME_W-1:0];
            REG_TILT_LIMIT: tilt_limit_ff <= csr_pwdata[TILT_W-1:0];
            REG_SPIN_DOWN:  spin_down_ff  <= csr_pwdata[SPIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ARM_DELAY:  csr_prdata = arm_delay_ff;
         REG_HOVER_DUR:  csr_prdata = hover_dur_ff;
         REG_TILT_LIMIT: csr_prdata = {{(CSR_DATA_W-TILT_W){1'b0}}, tilt_limit_ff};
         REG_SPIN_DOWN:  csr_prdata = {{(CSR_DATA_W-SPIN_W){1'b0}}, spin_down_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic in_valid_ff;
   logic out_free;
   logic req_take;
   logic advance;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // input register
   op_type                   op_ff;
   logic [TIME_W-1:0]        now_ff;
   logic                     healthy_ff;
   logic signed [ANGLE_W-1:0] roll_ff;
   logic signed [ANGLE_W-1:0] pitch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff      <= op_type'(req_op);
         now_ff     <= req_now_ms;
         healthy_ff <= req_imu_healthy;
         roll_ff    <= req_roll_angle;
         pitch_ff   <= req_pitch_angle;
      end
   end

   // sequencer state
   phase_type         phase_ff, phase_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic              emerg_ff, emerg_in;
   cause_type         cause_ff, cause_in;
   logic              pulse_in;
   logic              cut_in;

   // |angle| at 17 bits so that the most negative code maps to 32768
   logic [ANGLE_W:0]  roll_mag;
   logic [ANGLE_W:0]  pitch_mag;
   logic              tilt_over;
   logic [TIME_W-1:0] elapsed;

   assign roll_mag  = roll_ff[ANGLE_W-1] ? ({1'b0, ~roll_ff} + 1'b1) : {1'b0, roll_ff};
   assign pitch_mag = pitch_ff[ANGLE_W-1] ? ({1'b0, ~pitch_ff} + 1'b1) : {1'b0, pitch_ff};
   assign tilt_over = (roll_mag > {{(ANGLE_W+1-TILT_W){1'b0}}, tilt_limit_ff}) ||
                      (pitch_mag > {{(ANGLE_W+1-TILT_W){1'b0}}, tilt_limit_ff});
   assign elapsed   = now_ff - start_ff;

   // next state
   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      emerg_in = emerg_ff;
      cause_in = cause_ff;
      pulse_in = 1'b0;
      unique case (op_ff)
         OP_TICK: begin
            if (phase_ff == PH_HOVERING && !healthy_ff) begin
               phase_in = PH_HALTED;
               start_in = now_ff;
               emerg_in = 1'b1;
               cause_in = CAUSE_IMU;
               pulse_in = 1'b1;
            end else if (phase_ff == PH_HOVERING && tilt_over) begin
               phase_in = PH_HALTED;
               start_in = now_ff;
               emerg_in = 1'b1;
               cause_in = CAUSE_TILT;
               pulse_in = 1'b1;
            end else begin
               unique case (phase_ff)
                  PH_READY: begin
                     if (elapsed >= arm_delay_ff) begin
                        phase_in = PH_ARMING;
                        start_in = now_ff;
                     end
                  end
                  PH_HOVERING: begin
                     if (elapsed >= hover_dur_ff) begin
                        phase_in = PH_DISARMING;
                        start_in = now_ff;
                        pulse_in = 1'b1;
                     end
                  end
                  PH_DISARMING: begin
                     if (elapsed >= {{(TIME_W-SPIN_W){1'b0}}, spin_down_ff}) begin
                        phase_in = PH_HALTED;
                        start_in = now_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         OP_CAL_DONE: begin
            if (phase_ff == PH_BOOT) begin
               phase_in = PH_READY;
               start_in = now_ff;
            end
         end
         OP_ARM_DONE: begin
            if (phase_ff == PH_ARMING) begin
               phase_in = PH_HOVERING;
               start_in = now_ff;
            end
         end
         OP_EXT_STOP: begin
            if (phase_ff != PH_HALTED) begin
               phase_in = PH_HALTED;
               start_in = now_ff;
               emerg_in = 1'b1;
               cause_in = CAUSE_EXT;
               pulse_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // outputs of the update
   always_comb begin
      cut_in = emerg_in || (phase_in != PH_HOVERING);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BOOT;
         start_ff <= '0;
         emerg_ff <= 1'b0;
         cause_ff <= CAUSE_NONE;
      end else if (advance) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         emerg_ff <= emerg_in;
         cause_ff <= cause_in;
      end
   end

   // result register
   logic      rsp_valid_ff;
   phase_type rsp_phase_ff;
   logic      rsp_cut_ff;
   logic      rsp_pulse_ff;
   logic      rsp_emerg_ff;
   cause_type rsp_cause_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_phase_ff <= phase_in;
         rsp_cut_ff   <= cut_in;
         rsp_pulse_ff <= pulse_in;
         rsp_emerg_ff <= emerg_in;
         rsp_cause_ff <= cause_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_phase            = rsp_phase_ff;
   assign rsp_cut_power        = rsp_cut_ff;
   assign rsp_motor_stop_pulse = rsp_pulse_ff;
   assign rsp_emergency        = rsp_emerg_ff;
   assign rsp_stop_cause       = rsp_cause_ff;

   // checks
   a_halted_terminal: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALTED) |=> (phase_ff == PH_HALTED))
      else $error("left halted phase");

   a_emerg_means_halted: assert property (@(posedge clock) disable iff (reset)
      emerg_ff |-> (phase_ff == PH_HALTED))
      else $error("emergency latched outside halted");

   a_cause_matches_latch: assert property (@(posedge clock) disable iff (reset)
      (cause_ff != CAUSE_NONE) == emerg_ff)
      else $error("stop cause disagrees with emergency latch");

   a_pulse_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_motor_stop_pulse) |->
         (rsp_phase == PH_HALTED || rsp_phase == PH_DISARMING))
      else $error("motor stop pulse in a running phase");

   a_emerg_cuts_power: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_emergency) |-> rsp_cut_power)
      else $error("emergency result without power cut");

endmodule
